// ----- design/scs_pkg.sv -----
package scs_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int KEY_W        = 32;
    localparam int WGT_W        = 16;
    // A square of a Q8.8 weight never exceeds 2^30.
    localparam int SQ_W         = 2 * WGT_W - 1;
    localparam int SUM_W        = SQ_W + ADDR_W;
    localparam int DOT_W        = SUM_W + 1;
    localparam int PROD_W       = 2 * SUM_W;
    localparam int RES_W        = 16;
    localparam int Q_W          = 15;
    localparam int QIDX_W       = $clog2(Q_W);
    localparam int SCALE_SH     = 2 * (Q_W - 1);
    localparam int WORK_W       = PROD_W + SCALE_SH + 2;
    localparam int MCNT_W       = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        logic append_a;
        logic append_b;
        logic walk_init;
        logic walk_step;
        logic mul_load_p;
        logic mul_load_m;
        logic mul_step;
        logic root_init;
        logic root_add;
        logic root_cmp;
        logic emit;
    } scs_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic mul_done;
        logic root_done;
        logic out_busy;
    } scs_status_t;

endpackage

// ----- design/scs_dp.sv -----
module scs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scs_pkg::scs_cmd_t                   cmd,
    output scs_pkg::scs_status_t                status,
    input  logic signed [scs_pkg::KEY_W-1:0]    key,
    input  logic signed [scs_pkg::WGT_W-1:0]    weight,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [scs_pkg::RES_W-1:0]    similarity,
    output logic                                overflow
);
    import scs_pkg::*;

    logic [KEY_W-1:0] keys_a_mem    [MAX_ELEMENTS];
    logic [WGT_W-1:0] weights_a_mem [MAX_ELEMENTS];
    logic [KEY_W-1:0] keys_b_mem    [MAX_ELEMENTS];
    logic [WGT_W-1:0] weights_b_mem [MAX_ELEMENTS];

    logic [CNT_W-1:0] cnt_a_reg, cnt_b_reg;
    logic             drop_reg;
    logic             out_valid_reg;
    logic signed [RES_W-1:0] sim_reg;
    logic             ovf_reg;

    logic [CNT_W-1:0] pa_reg, pb_reg;
    logic signed [KEY_W-1:0] ka_reg, kb_reg;
    logic signed [WGT_W-1:0] wa_reg, wb_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [SUM_W-1:0] na_reg, nb_reg;

    logic [PROD_W-1:0] mcand_reg, acc_reg, p_reg;
    logic [SUM_W-1:0]  mplier_reg;
    logic [MCNT_W-1:0] mcnt_reg;

    logic [WORK_W-1:0] r_reg, s_reg, tsh_reg, psh_reg, trial_reg;
    logic [Q_W-1:0]    q_reg;
    logic [QIDX_W-1:0] qidx_reg;

    logic full_a, full_b;
    logic a_ok, b_ok, take_a, take_b, match;
    logic signed [2*WGT_W-1:0] prod_ab, sq_a, sq_b;
    logic [SUM_W-1:0] mag;
    logic accept;
    logic [WORK_W-1:0] tsh_upd;
    logic [Q_W-1:0] q_set;

    assign full_a = (cnt_a_reg == CNT_W'(MAX_ELEMENTS));
    assign full_b = (cnt_b_reg == CNT_W'(MAX_ELEMENTS));
    assign a_ok   = (pa_reg < cnt_a_reg);
    assign b_ok   = (pb_reg < cnt_b_reg);

    always_comb
    begin
        match  = 1'b0;
        take_a = a_ok;
        take_b = b_ok;
        if (a_ok && b_ok)
        begin
            if (ka_reg == kb_reg)
            begin
                match = 1'b1;
            end
            else if (ka_reg < kb_reg)
            begin
                take_b = 1'b0;
            end
            else
            begin
                take_a = 1'b0;
            end
        end
    end

    assign prod_ab = wa_reg * wb_reg;
    assign sq_a    = wa_reg * wa_reg;
    assign sq_b    = wb_reg * wb_reg;

    assign mag = dot_reg[DOT_W-1] ? SUM_W'(-dot_reg) : SUM_W'(dot_reg);

    assign accept  = (trial_reg <= r_reg);
    assign tsh_upd = accept ? (tsh_reg + (psh_reg << 1)) : tsh_reg;

    always_comb
    begin
        q_set = q_reg;
        q_set[qidx_reg] = accept;
    end

    assign status.walk_done = !a_ok && !b_ok;
    assign status.mul_done  = (mcnt_reg == MCNT_W'(SUM_W));
    assign status.root_done = (qidx_reg == '0);
    assign status.out_busy  = out_valid_reg && out_stall;

    // Storage arrays with registered reads at the walk pointers.
    always_ff @(posedge clk)
    begin
        if (cmd.append_a && !full_a)
        begin
            keys_a_mem[cnt_a_reg[ADDR_W-1:0]]    <= key;
            weights_a_mem[cnt_a_reg[ADDR_W-1:0]] <= weight;
        end
        if (cmd.append_b && !full_b)
        begin
            keys_b_mem[cnt_b_reg[ADDR_W-1:0]]    <= key;
            weights_b_mem[cnt_b_reg[ADDR_W-1:0]] <= weight;
        end
        ka_reg <= keys_a_mem[pa_reg[ADDR_W-1:0]];
        wa_reg <= weights_a_mem[pa_reg[ADDR_W-1:0]];
        kb_reg <= keys_b_mem[pb_reg[ADDR_W-1:0]];
        wb_reg <= weights_b_mem[pb_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append_a)
            begin
                if (full_a)
                    drop_reg <= 1'b1;
                else
                    cnt_a_reg <= cnt_a_reg + 1'b1;
            end
            if (cmd.append_b)
            begin
                if (full_b)
                    drop_reg <= 1'b1;
                else
                    cnt_b_reg <= cnt_b_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                cnt_a_reg     <= '0;
                cnt_b_reg     <= '0;
                drop_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            pa_reg  <= '0;
            pb_reg  <= '0;
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        if (cmd.walk_step)
        begin
            if (match)
                dot_reg <= dot_reg + DOT_W'(prod_ab);
            if (take_a)
            begin
                na_reg <= na_reg + SUM_W'(sq_a[SQ_W-1:0]);
                pa_reg <= pa_reg + 1'b1;
            end
            if (take_b)
            begin
                nb_reg <= nb_reg + SUM_W'(sq_b[SQ_W-1:0]);
                pb_reg <= pb_reg + 1'b1;
            end
        end

        // Shift-and-add multiplier, one multiplier bit per cycle.
        if (cmd.mul_load_p)
        begin
            mcand_reg  <= PROD_W'(na_reg);
            mplier_reg <= nb_reg;
            acc_reg    <= '0;
            mcnt_reg   <= '0;
        end
        if (cmd.mul_load_m)
        begin
            p_reg      <= acc_reg;
            mcand_reg  <= PROD_W'(mag);
            mplier_reg <= mag;
            acc_reg    <= '0;
            mcnt_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            mcnt_reg   <= mcnt_reg + 1'b1;
        end

        // Bitwise search for the largest q with q*q*P <= R, keeping q*q*P
        // and the shifted cross term as running sums.
        if (cmd.root_init)
        begin
            r_reg    <= WORK_W'(acc_reg) << SCALE_SH;
            s_reg    <= '0;
            tsh_reg  <= '0;
            psh_reg  <= WORK_W'(p_reg) << SCALE_SH;
            q_reg    <= '0;
            qidx_reg <= QIDX_W'(Q_W - 1);
        end
        if (cmd.root_add)
            trial_reg <= s_reg + tsh_reg + psh_reg;
        if (cmd.root_cmp)
        begin
            if (accept)
                s_reg <= trial_reg;
            q_reg    <= q_set;
            tsh_reg  <= tsh_upd >> 1;
            psh_reg  <= psh_reg >> 2;
            qidx_reg <= qidx_reg - 1'b1;
        end

        if (cmd.emit)
        begin
            if (p_reg == '0)
                sim_reg <= '0;
            else if (dot_reg[DOT_W-1])
                sim_reg <= -RES_W'(q_reg);
            else
                sim_reg <= RES_W'(q_reg);
            ovf_reg <= drop_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign similarity = sim_reg;
    assign overflow   = ovf_reg;

endmodule

// ----- design/scs_ctrl.sv -----
module scs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    output scs_pkg::scs_cmd_t     cmd,
    input  scs_pkg::scs_status_t  status
);
    import scs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_LOAD_P,
        S_MUL_P,
        S_LOAD_M,
        S_MUL_M,
        S_ROOT_INIT,
        S_ROOT_ADD,
        S_ROOT_CMP,
        S_EMIT
    } state_t;

    state_t state_reg;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_t'(operation))
                        OP_APPEND_A: cmd.append_a  = 1'b1;
                        OP_APPEND_B: cmd.append_b  = 1'b1;
                        OP_COMPUTE:  cmd.walk_init = 1'b1;
                        OP_NONE:     ;
                    endcase
                end
            end
            S_READ:      ;
            S_STEP:      cmd.walk_step  = !status.walk_done;
            S_LOAD_P:    cmd.mul_load_p = 1'b1;
            S_MUL_P:     cmd.mul_step   = !status.mul_done;
            S_LOAD_M:    cmd.mul_load_m = 1'b1;
            S_MUL_M:     cmd.mul_step   = !status.mul_done;
            S_ROOT_INIT: cmd.root_init  = 1'b1;
            S_ROOT_ADD:  cmd.root_add   = 1'b1;
            S_ROOT_CMP:  cmd.root_cmp   = 1'b1;
            S_EMIT:      cmd.emit       = !status.out_busy;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (op_t'(operation) == OP_COMPUTE))
                        state_reg <= S_READ;
                end
                S_READ:      state_reg <= S_STEP;
                S_STEP:      state_reg <= status.walk_done ? S_LOAD_P : S_READ;
                S_LOAD_P:    state_reg <= S_MUL_P;
                S_MUL_P:
                begin
                    if (status.mul_done)
                        state_reg <= S_LOAD_M;
                end
                S_LOAD_M:    state_reg <= S_MUL_M;
                S_MUL_M:
                begin
                    if (status.mul_done)
                        state_reg <= S_ROOT_INIT;
                end
                S_ROOT_INIT: state_reg <= S_ROOT_ADD;
                S_ROOT_ADD:  state_reg <= S_ROOT_CMP;
                S_ROOT_CMP:  state_reg <= status.root_done ? S_EMIT : S_ROOT_ADD;
                S_EMIT:
                begin
                    if (!status.out_busy)
                        state_reg <= S_IDLE;
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/sparse_cosine_similarity_top.sv -----
// Append transactions are accepted while idle and may follow back to back.
// After a compute transaction is accepted the input stalls while the block walks both lists in
// merge steps (at most count_a + count_b, each a read and a step state, plus a pair to end the
// walk), runs two serial multiplies and the 15-bit root search and loads the result register,
// which waits while an earlier result is still stalled; the result is valid on the next cycle.
// Reset clears the state machine, element counts, drop flag and output valid, not the memories.
module sparse_cosine_similarity_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic signed [scs_pkg::KEY_W-1:0]    key,
    input  logic signed [scs_pkg::WGT_W-1:0]    weight,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [scs_pkg::RES_W-1:0]    similarity,
    output logic                                overflow
);
    import scs_pkg::*;

    scs_cmd_t    cmd;
    scs_status_t status;

    scs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .cmd       (cmd),
        .status    (status)
    );

    scs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key        (key),
        .weight     (weight),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .overflow   (overflow)
    );

endmodule
